[rtl/lpq_pkg.sv]
// Package with shared types and constants for the log packet queue sender.
package lpq_pkg;

    localparam int unsigned QueueDepthDefault = 128;
    localparam int unsigned RecWords = 4;
    localparam int unsigned RecBytes = 32;
    localparam logic [7:0] MagicU = 8'h55;
    localparam logic [7:0] MagicL = 8'h4C;
    localparam logic [6:0] AddrReset = 7'h42;
    localparam logic [31:0] BackoffReset = 32'd10000;
    localparam logic [4:0] PayloadMax = 5'd16;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_ADDRESS = 2'd1,
        CFG_BACKOFF = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic start;
        logic [63:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

[rtl/lpq_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
module lpq_ram #(
    parameter int unsigned Width = 64,
    parameter int unsigned Depth = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/lpq_div1000.sv]
// Divide-by-1000 unit that retires one 16-bit dividend digit per cycle by reciprocal multiplication.
module lpq_div1000 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpq_pkg::t_div_req i_req,
    output lpq_pkg::t_div_rsp o_rsp
);
    import lpq_pkg::*;

    localparam logic [23:0] Recip125 = 24'd8589935;

    logic [63:0] r_num;
    logic [9:0]  r_rem;
    logic [15:0] r_quo;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic [25:0] part;
    logic [46:0] prod;
    logic [15:0] digit_q;
    logic [25:0] digit_x1000;
    logic [25:0] part_rem;

    assign part = {r_rem, r_num[63:48]};
    assign prod = {24'd0, part[25:3]} * {23'd0, Recip125};
    assign digit_q = prod[45:30];
    assign digit_x1000 = {digit_q, 10'd0} - {6'd0, digit_q, 4'd0} - {7'd0, digit_q, 3'd0};
    assign part_rem = part - digit_x1000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt <= 3'd4;
            r_num <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[47:0], 16'd0};
            r_rem <= part_rem[9:0];
            r_quo <= digit_q;
            r_cnt <= r_cnt - 3'd1;
            if (r_cnt == 3'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == 3'd1);
    assign o_rsp.quotient = {r_quo, digit_q};
endmodule

[rtl/log_packet_queue_i2c_sender.sv]
// Top level: log record ring with a byte-serial bus sender.
//
// Channel   Direction  Handshake        Payload
// command   in         start/busy       mode, record fields, time, ack mask
// config    in         i_cfg_we         i_cfg_index, i_cfg_data
// result    out        o_valid          tx_byte, byte_position, byte_acked, last_byte
//
// A push keeps busy high while the divide-by-1000 unit works, one 16-bit digit
// per cycle, then for the four record word writes into the store. A poll that
// sends first reads the four record words, then sends one byte per cycle, up to
// 33 bytes. Reset is synchronous; the store is not cleared. The receiver cannot
// stall; each result is shown for one cycle.
module log_packet_queue_i2c_sender #(
    parameter int unsigned QUEUE_DEPTH = lpq_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_mode,
    input  logic [7:0]  i_event_code,
    input  logic [7:0]  i_arg_a,
    input  logic [15:0] i_arg_b,
    input  logic [15:0] i_arg_c,
    input  logic [7:0]  i_payload_length,
    input  logic [63:0] i_payload_low,
    input  logic [63:0] i_payload_high,
    input  logic [63:0] i_time_us,
    input  logic [32:0] i_ack_mask,
    output logic        o_valid,
    output logic [7:0]  o_tx_byte,
    output logic [5:0]  o_byte_position,
    output logic        o_byte_acked,
    output logic        o_last_byte
);
    import lpq_pkg::*;

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned AddrW = PtrW + 2;

    t_state r_state, n_state;
    logic r_enable;
    logic [6:0] r_addr;
    logic [31:0] r_backoff;
    logic [PtrW-1:0] r_wp, r_rp;
    logic [15:0] r_seq;
    logic [7:0] r_drop;
    logic [63:0] r_retry;
    logic [1:0] r_word;
    logic [5:0] r_pos;
    logic [255:0] r_rec;
    logic [32:0] r_ack;
    logic [63:0] r_now;
    logic [31:0] r_ms;
    logic [7:0] r_ev, r_aa, r_len, r_dropc;
    logic [15:0] r_ab, r_ac, r_seqc;
    logic [127:0] r_pay;
    logic r_rd_pend;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic we;
    logic [AddrW-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;
    logic [PtrW-1:0] wp_next, rp_next;
    logic [255:0] rec;
    logic [7:0] cur_byte;
    logic acked;
    logic [4:0] len_c;
    logic [127:0] pay_mask;
    logic [1:0] word_prev;

    assign wp_next = (r_wp == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PtrW'(1);
    assign rp_next = (r_rp == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PtrW'(1);
    assign len_c = (r_len > 8'd16) ? PayloadMax : r_len[4:0];
    assign word_prev = r_word - 2'd1;

    always_comb begin
        pay_mask = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < len_c) begin
                pay_mask[i*8 +: 8] = 8'hFF;
            end
        end
    end

    assign rec = {r_pay & pay_mask, r_dropc, 3'b0, len_c, r_ac, r_ab, r_aa, r_ev, r_ms,
                  r_seqc, MagicL, MagicU};

    assign div_req.start = (r_state == ST_IDLE) && start && !i_mode
                           && (wp_next != r_rp);
    assign div_req.dividend = i_time_us;

    lpq_div1000 u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign we = (r_state == ST_WRITE);
    assign waddr = {r_wp, r_word};
    assign wdata = rec[r_word*64 +: 64];
    assign raddr = {r_rp, r_word};

    lpq_ram #(.Width(64), .Depth(QUEUE_DEPTH * RecWords)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign cur_byte = (r_pos == 6'd0) ? {r_addr, 1'b0} : r_rec[(r_pos - 6'd1)*8 +: 8];
    assign acked = r_ack[r_pos];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (!i_mode) begin
                        if (wp_next != r_rp) begin
                            n_state = ST_DIV;
                        end
                    end else if (r_enable && (r_rp != r_wp) && (i_time_us >= r_retry)) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_word == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (r_rd_pend && r_word == 2'd0) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!acked || r_pos == 6'd32) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_enable <= 1'b0;
            r_addr <= AddrReset;
            r_backoff <= BackoffReset;
            r_wp <= '0;
            r_rp <= '0;
            r_seq <= '0;
            r_drop <= '0;
            r_retry <= '0;
            r_word <= '0;
            r_pos <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_ADDRESS: r_addr <= i_cfg_data[6:0];
                    CFG_BACKOFF: r_backoff <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_word <= '0;
                    r_pos <= '0;
                    r_rd_pend <= 1'b0;
                    if (start && !i_mode && wp_next == r_rp && r_drop != 8'hFF) begin
                        r_drop <= r_drop + 8'd1;
                    end
                    if (div_req.start) begin
                        r_seq <= r_seq + 16'd1;
                        r_drop <= '0;
                    end
                end
                ST_WRITE: begin
                    r_word <= r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        r_wp <= wp_next;
                    end
                end
                ST_READ: begin
                    r_word <= r_word + 2'd1;
                    r_rd_pend <= 1'b1;
                end
                ST_SEND: begin
                    r_pos <= r_pos + 6'd1;
                    if (!acked) begin
                        r_retry <= r_now + {32'd0, r_backoff};
                    end else if (r_pos == 6'd32) begin
                        r_rp <= rp_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_ev <= i_event_code;
            r_aa <= i_arg_a;
            r_ab <= i_arg_b;
            r_ac <= i_arg_c;
            r_len <= i_payload_length;
            r_pay <= {i_payload_high, i_payload_low};
            r_ack <= i_ack_mask;
            r_now <= i_time_us;
            r_seqc <= r_seq;
            r_dropc <= r_drop;
        end
        if (div_rsp.done) begin
            r_ms <= div_rsp.quotient;
        end
        if (r_state == ST_READ && r_rd_pend) begin
            r_rec[word_prev*64 +: 64] <= rdata;
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_SEND);
    assign o_tx_byte = cur_byte;
    assign o_byte_position = r_pos;
    assign o_byte_acked = acked;
    assign o_last_byte = !acked || (r_pos == 6'd32);

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte |=> !o_valid) else $error("send continued after last byte");
    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_byte |=> o_valid && o_byte_position == $past(o_byte_position) + 6'd1)
        else $error("byte position skipped");
    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
endmodule
